// ===== design/brwu_pkg.sv =====
// Shared constants and types for the byte ring buffer with unget.
package brwu_pkg;

   localparam int BYTE_W = 8;
   localparam int CFG_W  = 9;
   localparam int FILL_W = 8;
   localparam int MODE_W = 2;

   localparam logic [MODE_W-1:0] MODE_PUSH  = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PULL  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_UNGET = 2'd2;

   localparam logic [FILL_W-1:0] FILL_SAT = 8'hFF;

   // Per-request result information handed from the control to the output stage.
   typedef struct packed {
      logic              ok;
      logic              from_store;
      logic [BYTE_W-1:0] wr_byte;
      logic [FILL_W-1:0] fill;
   } rsp_info_type;

endpackage

// ===== design/brwu_store.sv =====
// Byte store: single-port-write, single-port-read synchronous memory.
module brwu_store
   import brwu_pkg::*;
   #(parameter int DEPTH = 256,
     parameter int AW    = 8)
   (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [AW-1:0]     wr_addr,
   input  logic [BYTE_W-1:0] wr_data,
   input  logic              rd_en,
   input  logic [AW-1:0]     rd_addr,
   output logic [BYTE_W-1:0] rd_data
   );

   logic [BYTE_W-1:0] mem [DEPTH];
   logic [BYTE_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/brwu_ctrl.sv =====
// Ring control: ring size, read/write indices, fill count and store commands.
module brwu_ctrl
   import brwu_pkg::*;
   #(parameter int MAX_DEPTH = 256,
     parameter int AW        = 8)
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              accept,
   input  logic [MODE_W-1:0] mode,
   input  logic [BYTE_W-1:0] data_in,
   input  logic              cfg_wr,
   input  logic [CFG_W-1:0]  cfg_depth,
   output logic              wr_en,
   output logic [AW-1:0]     wr_addr,
   output logic [BYTE_W-1:0] wr_data,
   output logic              rd_en,
   output logic [AW-1:0]     rd_addr,
   output rsp_info_type      info
   );

   localparam int SW = $clog2(MAX_DEPTH + 1);
   localparam int CW = (SW > CFG_W) ? SW : CFG_W;
   localparam int FW = (AW > FILL_W) ? AW : FILL_W;
   localparam int SIZE_RESET = (MAX_DEPTH < 256) ? MAX_DEPTH : 256;

   logic [SW-1:0] size_ff, size_in;
   logic [AW-1:0] wr_idx_ff, wr_idx_in;
   logic [AW-1:0] rd_idx_ff, rd_idx_in;
   logic [AW-1:0] count_ff, count_in;

   logic [CW-1:0] dep_w, dep_clamp;
   logic [SW-1:0] wr_inc, rd_inc;
   logic [AW-1:0] wr_next, rd_next, rd_prev;
   logic          full, empty;
   logic          do_push, do_pull, do_unget;

   // Clamp the written ring size to 2..MAX_DEPTH.
   always_comb begin
      dep_w = CW'(cfg_depth);
      if (dep_w < CW'(2)) begin
         dep_clamp = CW'(2);
      end else if (dep_w > CW'(MAX_DEPTH)) begin
         dep_clamp = CW'(MAX_DEPTH);
      end else begin
         dep_clamp = dep_w;
      end
   end

   always_comb begin
      wr_inc  = SW'(wr_idx_ff) + SW'(1);
      rd_inc  = SW'(rd_idx_ff) + SW'(1);
      wr_next = (wr_inc == size_ff) ? '0 : AW'(wr_inc);
      rd_next = (rd_inc == size_ff) ? '0 : AW'(rd_inc);
      rd_prev = (rd_idx_ff == '0) ? AW'(size_ff - SW'(1)) : rd_idx_ff - AW'(1);
      full    = (wr_next == rd_idx_ff);
      empty   = (rd_idx_ff == wr_idx_ff);
   end

   always_comb begin
      do_push  = 1'b0;
      do_pull  = 1'b0;
      do_unget = 1'b0;
      if (accept) begin
         unique case (mode)
            MODE_PUSH:  do_push  = !full;
            MODE_PULL:  do_pull  = !empty;
            MODE_UNGET: do_unget = !full;
            default:    ;
         endcase
      end
   end

   always_comb begin
      size_in   = size_ff;
      wr_idx_in = wr_idx_ff;
      rd_idx_in = rd_idx_ff;
      count_in  = count_ff;
      if (cfg_wr) begin
         // new ring size empties the buffer; stored bytes stay
         size_in   = SW'(dep_clamp);
         wr_idx_in = '0;
         rd_idx_in = '0;
         count_in  = '0;
      end else if (do_push) begin
         wr_idx_in = wr_next;
         count_in  = count_ff + AW'(1);
      end else if (do_pull) begin
         rd_idx_in = rd_next;
         count_in  = count_ff - AW'(1);
      end else if (do_unget) begin
         rd_idx_in = rd_prev;
         count_in  = count_ff + AW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff   <= SW'(SIZE_RESET);
         wr_idx_ff <= '0;
         rd_idx_ff <= '0;
         count_ff  <= '0;
      end else begin
         size_ff   <= size_in;
         wr_idx_ff <= wr_idx_in;
         rd_idx_ff <= rd_idx_in;
         count_ff  <= count_in;
      end
   end

   assign wr_en   = do_push || do_unget;
   assign wr_addr = do_unget ? rd_prev : wr_idx_ff;
   assign wr_data = data_in;
   assign rd_en   = do_pull;
   assign rd_addr = rd_idx_ff;

   always_comb begin
      info.ok         = do_push || do_pull || do_unget;
      info.from_store = do_pull;
      info.wr_byte    = data_in;
      // saturate the reported fill count
      if (FW'(count_in) > FW'(FILL_SAT)) begin
         info.fill = FILL_SAT;
      end else begin
         info.fill = FILL_W'(count_in);
      end
   end

`ifndef SYNTHESIS
   a_count_below_size: assert property (@(posedge clock) disable iff (reset)
      SW'(count_ff) < size_ff)
      else $error("fill count reached ring size");

   a_empty_matches_count: assert property (@(posedge clock) disable iff (reset)
      (rd_idx_ff == wr_idx_ff) == (count_ff == '0))
      else $error("index equality disagrees with fill count");

   a_cfg_empties: assert property (@(posedge clock) disable iff (reset)
      cfg_wr |=> (count_ff == '0) && (rd_idx_ff == '0) && (wr_idx_ff == '0))
      else $error("size write did not empty the ring");

   a_idx_in_ring: assert property (@(posedge clock) disable iff (reset)
      (SW'(rd_idx_ff) < size_ff) && (SW'(wr_idx_ff) < size_ff))
      else $error("index outside ring");
`endif

endmodule

// ===== design/byte_ring_buffer_with_unget.sv =====
// A request accepted at a clock edge has its result on rsp_* in the next cycle.
// Throughput: one request per cycle; busy stays low, each makes at most one store access.
// Pushes and ungets write the store; a pull reads it and the byte shows in the next cycle.
// Reset: synchronous, clears both indices and the fill count; ring size returns to 256,
// or to MAX_DEPTH when that is smaller.
// The receiver cannot stall: each result shows for exactly one cycle with rsp_strobe.
module byte_ring_buffer_with_unget
   import brwu_pkg::*;
   #(parameter int MAX_DEPTH = 256)
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [BYTE_W-1:0] req_data_in,
   output logic              rsp_strobe,
   output logic [BYTE_W-1:0] rsp_data_out,
   output logic              rsp_ok,
   output logic [FILL_W-1:0] rsp_fill_count,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_depth_in_use
   );

   localparam int AW = $clog2(MAX_DEPTH);

   logic              accept;
   logic              cfg_wr;
   logic              wr_en, rd_en;
   logic [AW-1:0]     wr_addr, rd_addr;
   logic [BYTE_W-1:0] wr_data, rd_data;
   rsp_info_type      info;
   rsp_info_type      info_ff;
   logic              strobe_ff;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;
   assign cfg_wr    = csr_valid && csr_ready;

   brwu_ctrl #(.MAX_DEPTH(MAX_DEPTH), .AW(AW)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .mode      (req_mode),
      .data_in   (req_data_in),
      .cfg_wr    (cfg_wr),
      .cfg_depth (csr_depth_in_use),
      .wr_en     (wr_en),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .rd_en     (rd_en),
      .rd_addr   (rd_addr),
      .info      (info)
   );

   brwu_store #(.DEPTH(MAX_DEPTH), .AW(AW)) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         strobe_ff <= 1'b0;
      end else begin
         strobe_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         info_ff <= info;
      end
   end

   // pulled byte comes straight from the store read register
   always_comb begin
      if (!info_ff.ok) begin
         rsp_data_out = '0;
      end else if (info_ff.from_store) begin
         rsp_data_out = rd_data;
      end else begin
         rsp_data_out = info_ff.wr_byte;
      end
   end

   assign rsp_strobe     = strobe_ff;
   assign rsp_ok         = info_ff.ok;
   assign rsp_fill_count = info_ff.fill;

`ifndef SYNTHESIS
   a_one_rsp_per_req: assert property (@(posedge clock) disable iff (reset)
      accept |=> rsp_strobe)
      else $error("request produced no response");

   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      !accept |=> !rsp_strobe)
      else $error("response without request");

   a_fail_zero_data: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && !rsp_ok) |-> (rsp_data_out == '0))
      else $error("refused request returned data");
`endif

endmodule

// ===== tb/brwu_checker.sv =====
// Scoreboard for the byte ring buffer: tracks ring state, predicts each result, compares.
`timescale 1ns / 100ps

module brwu_checker
   import brwu_pkg::*;
   #(parameter int MAX_DEPTH = 256)
   (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic              busy,
   input  logic [MODE_W-1:0] req_mode,
   input  logic [BYTE_W-1:0] req_data_in,
   input  logic              rsp_strobe,
   input  logic [BYTE_W-1:0] rsp_data_out,
   input  logic              rsp_ok,
   input  logic [FILL_W-1:0] rsp_fill_count,
   input  logic              csr_valid,
   input  logic              csr_ready,
   input  logic [CFG_W-1:0]  csr_depth_in_use,
   output int                fail_count,
   output int                outstanding,
   output int                refused_count,
   output int                checked_count
   );

   typedef struct packed {
      logic [BYTE_W-1:0] data_out;
      logic              ok;
      logic [FILL_W-1:0] fill_count;
   } ring_result_type;

   logic [BYTE_W-1:0] ring_bytes [MAX_DEPTH];
   int unsigned       head_idx = 0;
   int unsigned       tail_idx = 0;
   logic [CFG_W-1:0]  ring_depth = 9'd256;
   ring_result_type   predicted_results [$];
   int                errors = 0;
   int                refusals = 0;
   int                compared = 0;

   function automatic int unsigned bytes_held(input int unsigned len);
      if (head_idx <= tail_idx)
         return tail_idx - head_idx;
      return len - head_idx + tail_idx;
   endfunction

   // Apply one request to the shadow ring and return the result it should give.
   function automatic ring_result_type apply_ring_request(input logic [MODE_W-1:0] op,
                                                          input logic [BYTE_W-1:0] value_in);
      int unsigned     len;
      int unsigned     held;
      int unsigned     slot;
      ring_result_type res;
      len = (ring_depth < 2) ? 2 : ((ring_depth > MAX_DEPTH) ? MAX_DEPTH : ring_depth);
      if (tail_idx >= len)
         tail_idx = 0;
      if (head_idx >= len)
         head_idx = 0;
      res = '0;
      case (op)
         MODE_PUSH: begin
            if (len - bytes_held(len) > 1) begin
               ring_bytes[tail_idx] = value_in;
               tail_idx = (tail_idx + 1 == len) ? 0 : tail_idx + 1;
               res.data_out = value_in;
               res.ok = 1'b1;
            end
         end
         MODE_PULL: begin
            if (head_idx != tail_idx) begin
               res.data_out = ring_bytes[head_idx];
               head_idx = (head_idx + 1 == len) ? 0 : head_idx + 1;
               res.ok = 1'b1;
            end
         end
         MODE_UNGET: begin
            // step the head back one slot; refused when it would meet the tail
            slot = (head_idx == 0) ? len - 1 : head_idx - 1;
            if (slot != tail_idx) begin
               ring_bytes[slot] = value_in;
               head_idx = slot;
               res.data_out = value_in;
               res.ok = 1'b1;
            end
         end
         default: ;
      endcase
      held = bytes_held(len);
      res.fill_count = (held > 255) ? FILL_SAT : FILL_W'(held);
      return res;
   endfunction

   always @(posedge clock) begin
      ring_result_type got;
      ring_result_type want;
      if (reset) begin
         head_idx = 0;
         tail_idx = 0;
         ring_depth = 9'd256;
         predicted_results.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            ring_depth = csr_depth_in_use;
            head_idx = 0;
            tail_idx = 0;
         end
         if (start && !busy)
            predicted_results.push_back(apply_ring_request(req_mode, req_data_in));
         if (rsp_strobe) begin
            got = '{rsp_data_out, rsp_ok, rsp_fill_count};
            if (predicted_results.size() == 0) begin
               errors++;
               if (errors <= 10)
                  $display("%0t: result with nothing pending: data %h ok %b fill %0d",
                           $realtime, got.data_out, got.ok, got.fill_count);
            end else begin
               want = predicted_results.pop_front();
               compared++;
               if (!want.ok)
                  refusals++;
               if (got !== want) begin
                  errors++;
                  if (errors <= 10)
                     $display({"%0t: mismatch: expected data %h ok %b fill %0d, ",
                               "got data %h ok %b fill %0d"},
                              $realtime, want.data_out, want.ok, want.fill_count,
                              got.data_out, got.ok, got.fill_count);
               end
            end
         end
      end
      fail_count    <= errors;
      outstanding   <= predicted_results.size();
      refused_count <= refusals;
      checked_count <= compared;
   end

endmodule

// ===== tb/tb_byte_ring_buffer_with_unget.sv =====
// Top of the ring buffer testbench: clock, reset, request and ring-size stimulus, verdict.
`timescale 1ns / 100ps

module tb_byte_ring_buffer_with_unget;
   import brwu_pkg::*;

   localparam int MAX_DEPTH   = 256;
   localparam int PHASES      = 9;
   localparam int STALL_LIMIT = 1000;
   localparam logic [MODE_W-1:0] MODE_SPARE = 2'd3;

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              start = 1'b0;
   logic              busy;
   logic [MODE_W-1:0] req_mode = MODE_PUSH;
   logic [BYTE_W-1:0] req_data_in = '0;
   logic              rsp_strobe;
   logic [BYTE_W-1:0] rsp_data_out;
   logic              rsp_ok;
   logic [FILL_W-1:0] rsp_fill_count;
   logic              csr_valid = 1'b0;
   logic              csr_ready;
   logic [CFG_W-1:0]  csr_depth_in_use = '0;

   int fail_count;
   int outstanding;
   int refused_count;
   int checked_count;

   int phase_depth [PHASES] = '{4, 2, 0, 1, 3, 256, 511, 17, 2};
   int phase_idle  [PHASES] = '{0, 70, 33, 0, 70, 0, 33, 70, 33};
   int phase_items [PHASES] = '{100, 100, 60, 60, 100, 620, 150, 150, 150};
   int mode_sent   [4] = '{0, 0, 0, 0};
   int idle_pct = 0;
   int quiet_cycles = 0;

   always #1 clock = ~clock;

   byte_ring_buffer_with_unget #(.MAX_DEPTH(MAX_DEPTH)) DUT (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_data_in      (req_data_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_data_out     (rsp_data_out),
      .rsp_ok           (rsp_ok),
      .rsp_fill_count   (rsp_fill_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_depth_in_use (csr_depth_in_use)
   );

   brwu_checker #(.MAX_DEPTH(MAX_DEPTH)) u_checker (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_mode         (req_mode),
      .req_data_in      (req_data_in),
      .rsp_strobe       (rsp_strobe),
      .rsp_data_out     (rsp_data_out),
      .rsp_ok           (rsp_ok),
      .rsp_fill_count   (rsp_fill_count),
      .csr_valid        (csr_valid),
      .csr_ready        (csr_ready),
      .csr_depth_in_use (csr_depth_in_use),
      .fail_count       (fail_count),
      .outstanding      (outstanding),
      .refused_count    (refused_count),
      .checked_count    (checked_count)
   );

   // Called just after a rising edge; returns just after the edge that took the request.
   task automatic send_request(input logic [MODE_W-1:0] op, input logic [BYTE_W-1:0] value_in);
      while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_mode <= op;
      req_data_in <= value_in;
      do @(posedge clock); while (busy);
      mode_sent[op]++;
   endtask

   // Drain all pending results, then write a new ring size.
   task automatic program_ring_depth(input logic [CFG_W-1:0] depth);
      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      csr_valid <= 1'b1;
      csr_depth_in_use <= depth;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   always @(posedge clock) begin
      if ((start && !busy) || (csr_valid && csr_ready) || rsp_strobe) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles == STALL_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $realtime, STALL_LIMIT);
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int                size;
      int                seg_len;
      int                roll;
      logic              filling;
      logic [MODE_W-1:0] op;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // a few requests at the reset ring size
      send_request(MODE_PULL, 8'hFF);
      send_request(MODE_SPARE, 8'h5A);
      send_request(MODE_PUSH, 8'hFF);
      send_request(MODE_PULL, 8'h00);

      for (int p = 0; p < PHASES; p++) begin
         if (p == PHASES - 1)
            phase_depth[p] = $urandom_range(300, 2);
         program_ring_depth(CFG_W'(phase_depth[p]));
         idle_pct = phase_idle[p];
         if (p == 0) begin
            // ring of four: fill to capacity, refuse, wrap the head backward, empty out
            send_request(MODE_PUSH, 8'h00);
            send_request(MODE_PUSH, 8'h80);
            send_request(MODE_PUSH, 8'h7F);
            send_request(MODE_PUSH, 8'h01);
            send_request(MODE_UNGET, 8'h42);
            send_request(MODE_SPARE, 8'hFF);
            send_request(MODE_PULL, 8'hFF);
            send_request(MODE_UNGET, 8'hC3);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'hAA);
            send_request(MODE_UNGET, 8'h11);
            send_request(MODE_UNGET, 8'h22);
            send_request(MODE_UNGET, 8'h33);
            send_request(MODE_UNGET, 8'h44);
            send_request(MODE_PUSH, 8'h55);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'h00);
            send_request(MODE_PULL, 8'h00);
         end
         size = (phase_depth[p] < 2) ? 2 :
                ((phase_depth[p] > MAX_DEPTH) ? MAX_DEPTH : phase_depth[p]);
         // alternate fill and drain tides long enough to hit full and empty
         seg_len = size + size / 4 + 4;
         filling = 1'b1;
         for (int n = 0; n < phase_items[p]; n++) begin
            if (n % seg_len == seg_len - 1)
               filling = !filling;
            roll = $urandom_range(99);
            if (roll < 84)
               op = filling ? MODE_PUSH : MODE_PULL;
            else if (roll < 93)
               op = filling ? MODE_UNGET : MODE_PUSH;
            else if (roll < 97)
               op = filling ? MODE_PULL : MODE_UNGET;
            else
               op = MODE_SPARE;
            send_request(op, BYTE_W'($urandom_range(255)));
         end
      end

      start <= 1'b0;
      do @(posedge clock); while (outstanding != 0);
      repeat (4) @(posedge clock);

      $display({"Ran %0d requests (%0d push, %0d pull, %0d unget, %0d unused mode), ",
                "%0d refused."},
               mode_sent[MODE_PUSH] + mode_sent[MODE_PULL] + mode_sent[MODE_UNGET]
               + mode_sent[MODE_SPARE], mode_sent[MODE_PUSH], mode_sent[MODE_PULL],
               mode_sent[MODE_UNGET], mode_sent[MODE_SPARE], refused_count);
      $display("Checked %0d results over %0d ring sizes, from clamped 0 and 1 up to 511.",
               checked_count, PHASES + 1);
      if (fail_count == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule

// ===== sim.f =====
design/brwu_pkg.sv
design/brwu_store.sv
design/brwu_ctrl.sv
design/byte_ring_buffer_with_unget.sv
tb/brwu_checker.sv
tb/tb_byte_ring_buffer_with_unget.sv
